@@ rtl/ptms_pkg.sv @@
// Shared types and constants for the PWM tone and melody sequencer.
`default_nettype none

package ptms_pkg;

   localparam int unsigned QUEUE_DEPTH = 8;
   localparam int unsigned SLOT_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned OP_W     = 3;
   localparam int unsigned FREQ_W   = 16;
   localparam int unsigned DUR_W    = 16;
   localparam int unsigned NSLOT_W  = 3;
   localparam int unsigned COUNT_W  = 4;
   localparam int unsigned CLK_W    = 27;
   localparam int unsigned PERIOD_W = 27;
   localparam int unsigned LEVEL_W  = 26;
   localparam int unsigned DIV_CNT_W = $clog2(CLK_W + 1);

   localparam logic [CLK_W-1:0]    CLOCK_RESET  = CLK_W'(266000000 / 4);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(65535);

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 3'd0,
      OP_TONE   = 3'd1,
      OP_WRITE  = 3'd2,
      OP_MELODY = 3'd3,
      OP_STOP   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIVIDE,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [DUR_W-1:0]  dur;
   } note_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [SLOT_W-1:0] addr;
      note_type          wdata;
   } ram_req_type;

   typedef struct packed {
      logic              start;
      logic [CLK_W-1:0]  dividend;
      logic [FREQ_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [CLK_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ rtl/ptms_if.sv @@
// Handshake channel interfaces: command in, PWM status out, clock register write.
`default_nettype none

interface ptms_req_if;
   logic                          valid;
   logic                          ready;
   logic [ptms_pkg::OP_W-1:0]     operation;
   logic [ptms_pkg::FREQ_W-1:0]   frequency;
   logic [ptms_pkg::DUR_W-1:0]    length_ms;
   logic [ptms_pkg::NSLOT_W-1:0]  note_slot;
   logic [ptms_pkg::COUNT_W-1:0]  melody_notes;

   modport source (output valid, operation, frequency, length_ms, note_slot,
                   melody_notes, input ready);
   modport sink (input valid, operation, frequency, length_ms, note_slot,
                 melody_notes, output ready);
endinterface

interface ptms_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ptms_pkg::PERIOD_W-1:0]  pwm_period;
   logic [ptms_pkg::LEVEL_W-1:0]   pwm_level;
   logic                           tone_busy;
   logic                           melody_busy;

   modport source (output valid, pwm_period, pwm_level, tone_busy, melody_busy,
                   input ready);
   modport sink (input valid, pwm_period, pwm_level, tone_busy, melody_busy,
                 output ready);
endinterface

interface ptms_csr_if;
   logic                        valid;
   logic                        ready;
   logic [ptms_pkg::CLK_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/ptms_note_ram.sv @@
// Note queue memory: one write and one registered read per cycle, on a shared address.
`default_nettype none

module ptms_note_ram (
   input  wire logic                  clock,
   input  wire ptms_pkg::ram_req_type req,
   output ptms_pkg::note_type         rd_data
);

   ptms_pkg::note_type notes_ff [ptms_pkg::QUEUE_DEPTH];
   ptms_pkg::note_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         notes_ff[req.addr] <= req.wdata;
      end
      if (req.rd_en) begin
         rd_data_ff <= notes_ff[req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/ptms_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module ptms_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ptms_pkg::div_req_type req,
   output ptms_pkg::div_rsp_type      rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [ptms_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ptms_pkg::FREQ_W-1:0]     rem_ff, rem_in;
   logic [ptms_pkg::FREQ_W-1:0]     dvs_ff, dvs_in;
   logic [ptms_pkg::CLK_W-1:0]      quo_ff, quo_in;
   logic [ptms_pkg::FREQ_W:0]       shifted;
   logic [ptms_pkg::FREQ_W:0]       diff;
   logic                            fits;

   // remainder stays below the divisor, so the difference fits FREQ_W bits
   assign shifted = {rem_ff, quo_ff[ptms_pkg::CLK_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = ptms_pkg::DIV_CNT_W'(ptms_pkg::CLK_W);
         rem_in  = '0;
         dvs_in  = req.divisor;
         quo_in  = req.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[ptms_pkg::FREQ_W-1:0] : shifted[ptms_pkg::FREQ_W-1:0];
         quo_in = {quo_ff[ptms_pkg::CLK_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ptms_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

@@ rtl/pwm_tone_melody_sequencer.sv @@
// Top level of the PWM tone and melody sequencer.
`default_nettype none

// Buzzer tone sequencer. Each req beat is one command (millisecond tick,
// start tone, write note, start melody, stop) and yields exactly one rsp beat
// that shows the PWM wrap value, compare level and busy flags after the
// command. A sounding tone programs a divider of tone_clock_hz / frequency:
// wrap = divider - 1, level = divider / 2; a divider of zero gives zero for
// both, and frequency zero is a rest that keeps the wrap value. Notes of a
// melody live in an 8-entry note memory with a synchronous read; a tick
// that expires a melody note reads the next entry and starts it. Queue
// entries have no reset: start a melody only over written slots. Commands
// are taken one at a time; anything that starts a sounding tone goes
// through the serial divider, which resolves one quotient bit per cycle
// over 27 bits. A new command is taken while the last rsp beat still
// waits. The clock register write port is always ready and should only
// be used while no command is in flight. No clearing pass after reset.
module pwm_tone_melody_sequencer (
   input  wire logic  clock,
   input  wire logic  reset,
   ptms_req_if.sink   req_chan,
   ptms_rsp_if.source rsp_chan,
   ptms_csr_if.sink   csr_chan
);

   ptms_pkg::state_type             state_ff, state_in;
   logic [ptms_pkg::CLK_W-1:0]      clk_hz_ff, clk_hz_in;
   logic [ptms_pkg::DUR_W-1:0]      rem_ff, rem_in;
   logic                            tone_on_ff, tone_on_in;
   logic                            melody_on_ff, melody_on_in;
   logic [ptms_pkg::QPTR_W-1:0]     qlen_ff, qlen_in;
   logic [ptms_pkg::QPTR_W-1:0]     qpos_ff, qpos_in;
   logic [ptms_pkg::PERIOD_W-1:0]   period_ff, period_in;
   logic [ptms_pkg::LEVEL_W-1:0]    level_ff, level_in;

   // rsp output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ptms_pkg::PERIOD_W-1:0]   out_period_ff, out_period_in;
   logic [ptms_pkg::LEVEL_W-1:0]    out_level_ff, out_level_in;
   logic                            out_tone_ff, out_tone_in;
   logic                            out_melody_ff, out_melody_in;

   // tone start request, from a command or from a fetched note
   logic                            bt_go;
   logic [ptms_pkg::FREQ_W-1:0]     bt_freq;
   logic [ptms_pkg::DUR_W-1:0]      bt_dur;
   logic [ptms_pkg::DUR_W-1:0]      tick_rem;

   ptms_pkg::ram_req_type           ram_req;
   ptms_pkg::note_type              ram_rdata;
   ptms_pkg::div_req_type           div_req;
   ptms_pkg::div_rsp_type           div_rsp;

   ptms_note_ram u_note_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (ram_rdata)
   );

   ptms_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_chan.ready = (state_ff == ptms_pkg::ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign tick_rem = (rem_ff == '0) ? '0 : rem_ff - 1'b1;

   always_comb begin
      state_in      = state_ff;
      clk_hz_in     = csr_chan.valid ? csr_chan.data : clk_hz_ff;
      rem_in        = rem_ff;
      tone_on_in    = tone_on_ff;
      melody_on_in  = melody_on_ff;
      qlen_in       = qlen_ff;
      qpos_in       = qpos_ff;
      period_in     = period_ff;
      level_in      = level_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_period_in = out_period_ff;
      out_level_in  = out_level_ff;
      out_tone_in   = out_tone_ff;
      out_melody_in = out_melody_ff;
      bt_go         = 1'b0;
      bt_freq       = req_chan.frequency;
      bt_dur        = req_chan.length_ms;
      ram_req       = '0;
      ram_req.addr  = qpos_ff[ptms_pkg::SLOT_W-1:0];
      div_req.start    = 1'b0;
      div_req.dividend = clk_hz_ff;
      div_req.divisor  = req_chan.frequency;

      case (state_ff)
         ptms_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ptms_pkg::ST_REPLY;
               case (req_chan.operation)
                  ptms_pkg::OP_TICK: begin
                     if (tone_on_ff) begin
                        rem_in = tick_rem;
                        if (tick_rem == '0) begin
                           level_in   = '0;
                           tone_on_in = 1'b0;
                           if (melody_on_ff && (qpos_ff < qlen_ff)) begin
                              // next queued note: read now, start it next cycle
                              ram_req.rd_en = 1'b1;
                              qpos_in       = qpos_ff + 1'b1;
                              state_in      = ptms_pkg::ST_FETCH;
                           end else begin
                              melody_on_in = 1'b0;
                           end
                        end
                     end
                  end
                  ptms_pkg::OP_TONE: begin
                     melody_on_in = 1'b0;
                     bt_go        = 1'b1;
                  end
                  ptms_pkg::OP_WRITE: begin
                     ram_req.wr_en      = 32'(req_chan.note_slot) < ptms_pkg::QUEUE_DEPTH;
                     ram_req.addr       = ptms_pkg::SLOT_W'(req_chan.note_slot);
                     ram_req.wdata.freq = req_chan.frequency;
                     ram_req.wdata.dur  = req_chan.length_ms;
                  end
                  ptms_pkg::OP_MELODY: begin
                     qlen_in = (32'(req_chan.melody_notes) > ptms_pkg::QUEUE_DEPTH) ?
                               ptms_pkg::QPTR_W'(ptms_pkg::QUEUE_DEPTH) :
                               ptms_pkg::QPTR_W'(req_chan.melody_notes);
                     qpos_in      = '0;
                     melody_on_in = 1'b1;
                     bt_go        = 1'b1;
                  end
                  ptms_pkg::OP_STOP: begin
                     level_in     = '0;
                     tone_on_in   = 1'b0;
                     melody_on_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ptms_pkg::ST_FETCH: begin
            bt_go   = 1'b1;
            bt_freq = ram_rdata.freq;
            bt_dur  = ram_rdata.dur;
         end
         ptms_pkg::ST_DIVIDE: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient == '0) begin
                  period_in = '0;
                  level_in  = '0;
               end else begin
                  period_in = ptms_pkg::PERIOD_W'(div_rsp.quotient - 1'b1);
                  level_in  = div_rsp.quotient[ptms_pkg::CLK_W-1:1];
               end
               state_in = ptms_pkg::ST_REPLY;
            end
         end
         ptms_pkg::ST_REPLY: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               out_period_in = period_ff;
               out_level_in  = level_ff;
               out_tone_in   = tone_on_ff;
               out_melody_in = melody_on_ff;
               state_in      = ptms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptms_pkg::ST_IDLE;
         end
      endcase

      // tone start: rests finish at once, sounding tones go through the divider
      if (bt_go) begin
         tone_on_in = 1'b1;
         rem_in     = bt_dur;
         if (bt_freq != '0) begin
            div_req.start   = 1'b1;
            div_req.divisor = bt_freq;
            state_in        = ptms_pkg::ST_DIVIDE;
         end else begin
            level_in = '0;
            state_in = ptms_pkg::ST_REPLY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptms_pkg::ST_IDLE;
         clk_hz_ff    <= ptms_pkg::CLOCK_RESET;
         rem_ff       <= '0;
         tone_on_ff   <= 1'b0;
         melody_on_ff <= 1'b0;
         qlen_ff      <= '0;
         qpos_ff      <= '0;
         period_ff    <= ptms_pkg::PERIOD_RESET;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clk_hz_ff    <= clk_hz_in;
         rem_ff       <= rem_in;
         tone_on_ff   <= tone_on_in;
         melody_on_ff <= melody_on_in;
         qlen_ff      <= qlen_in;
         qpos_ff      <= qpos_in;
         period_ff    <= period_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_period_ff <= out_period_in;
      out_level_ff  <= out_level_in;
      out_tone_ff   <= out_tone_in;
      out_melody_ff <= out_melody_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pwm_period  = out_period_ff;
   assign rsp_chan.pwm_level   = out_level_ff;
   assign rsp_chan.tone_busy   = out_tone_ff;
   assign rsp_chan.melody_busy = out_melody_ff;

   // between commands a running melody always has a note timing
   a_melody_has_tone: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptms_pkg::ST_IDLE && melody_on_ff) |-> tone_on_ff)
      else $error("melody active with no tone timing");

   a_qpos_bound: assert property (@(posedge clock) disable iff (reset)
      (qpos_ff <= qlen_ff) && (32'(qlen_ff) <= ptms_pkg::QUEUE_DEPTH))
      else $error("queue position beyond queue length");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ptms_pkg::ST_DIVIDE))
      else $error("divider finished outside divide state");

   a_level_le_period: assert property (@(posedge clock) disable iff (reset)
      (level_ff == '0) || (level_ff <= period_ff))
      else $error("compare level above wrap value");

endmodule

`default_nettype wire

@@ test/ptms_tb_pkg.sv @@
// Command and status beat types plus the status scoreboard for the tone sequencer bench.
`timescale 1ns / 100ps

package ptms_tb_pkg;
   import ptms_pkg::*;

   // Operation codes the block must ignore.
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [FREQ_W-1:0]  frequency;
      logic [DUR_W-1:0]   length_ms;
      logic [NSLOT_W-1:0] note_slot;
      logic [COUNT_W-1:0] melody_notes;
   } tone_cmd_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] pwm_period;
      logic [LEVEL_W-1:0]  pwm_level;
      logic                tone_busy;
      logic                melody_busy;
   } pwm_status_type;

   class tone_scoreboard;
      int unsigned            clock_hz;
      logic [FREQ_W-1:0]      note_freq [QUEUE_DEPTH];
      logic [DUR_W-1:0]       note_dur [QUEUE_DEPTH];
      logic [DUR_W-1:0]       ms_left;
      bit                     sounding;
      bit                     in_melody;
      int unsigned            notes_total;
      int unsigned            next_note;
      logic [PERIOD_W-1:0]    wrap_value;
      logic [LEVEL_W-1:0]     compare_level;
      pwm_status_type         expected_status [$];

      int unsigned            errors;
      int unsigned            checked;
      int unsigned            op_seen [QUEUE_DEPTH];
      int unsigned            unknown_seen;
      int unsigned            notes_played;
      int unsigned            melodies_done;

      function new();
         clock_hz      = CLOCK_RESET;
         ms_left       = '0;
         sounding      = 1'b0;
         in_melody     = 1'b0;
         notes_total   = 0;
         next_note     = 0;
         wrap_value    = PERIOD_RESET;
         compare_level = '0;
      endfunction

      function void set_tone_clock(int unsigned hz);
         clock_hz = hz;
      endfunction

      function int unsigned pending();
         return expected_status.size();
      endfunction

      function bit busy();
         return sounding || in_melody;
      endfunction

      // Program the divider and arm the millisecond countdown.
      function void start_note(logic [FREQ_W-1:0] freq, logic [DUR_W-1:0] dur);
         int unsigned divider;
         if (freq != '0) begin
            divider = clock_hz / 32'(freq);
            if (divider == 0) begin
               wrap_value    = '0;
               compare_level = '0;
            end else begin
               wrap_value    = PERIOD_W'(divider - 1);
               compare_level = LEVEL_W'(divider >> 1);
            end
         end else begin
            compare_level = '0;
         end
         sounding = 1'b1;
         ms_left  = dur;
      endfunction

      function void note_command(tone_cmd_type cmd);
         op_seen[cmd.operation]++;
         case (cmd.operation)
            OP_TICK: begin
               if (sounding) begin
                  if (ms_left != '0) ms_left--;
                  if (ms_left == '0) begin
                     compare_level = '0;
                     sounding      = 1'b0;
                     if (in_melody && next_note < notes_total) begin
                        start_note(note_freq[next_note], note_dur[next_note]);
                        next_note++;
                        notes_played++;
                     end else begin
                        if (in_melody) melodies_done++;
                        in_melody = 1'b0;
                     end
                  end
               end
            end
            OP_TONE: begin
               in_melody = 1'b0;
               start_note(cmd.frequency, cmd.length_ms);
            end
            OP_WRITE: begin
               note_freq[cmd.note_slot] = cmd.frequency;
               note_dur[cmd.note_slot]  = cmd.length_ms;
            end
            OP_MELODY: begin
               notes_total = (cmd.melody_notes > QUEUE_DEPTH) ? QUEUE_DEPTH : cmd.melody_notes;
               next_note   = 0;
               in_melody   = 1'b1;
               start_note(cmd.frequency, cmd.length_ms);
            end
            OP_STOP: begin
               compare_level = '0;
               sounding      = 1'b0;
               in_melody     = 1'b0;
            end
            default: unknown_seen++;
         endcase
         expected_status.push_back('{pwm_period: wrap_value, pwm_level: compare_level,
                                     tone_busy: sounding, melody_busy: in_melody});
      endfunction

      function void check_status(pwm_status_type got);
         pwm_status_type want;
         checked++;
         if (expected_status.size() == 0) begin
            $error("status beat with none expected: period %0d level %0d busy %0b/%0b",
                   got.pwm_period, got.pwm_level, got.tone_busy, got.melody_busy);
            errors++;
            return;
         end
         want = expected_status.pop_front();
         if (got.pwm_period !== want.pwm_period) begin
            $error("pwm_period: expected %0d, got %0d", want.pwm_period, got.pwm_period);
            errors++;
         end
         if (got.pwm_level !== want.pwm_level) begin
            $error("pwm_level: expected %0d, got %0d", want.pwm_level, got.pwm_level);
            errors++;
         end
         if (got.tone_busy !== want.tone_busy) begin
            $error("tone_busy: expected %0b, got %0b", want.tone_busy, got.tone_busy);
            errors++;
         end
         if (got.melody_busy !== want.melody_busy) begin
            $error("melody_busy: expected %0b, got %0b", want.melody_busy, got.melody_busy);
            errors++;
         end
      endfunction
   endclass

endpackage

@@ test/tb_pwm_tone_melody_sequencer.sv @@
// Top-level bench for the PWM tone and melody sequencer: directed and random commands.
`timescale 1ns / 100ps

module tb_pwm_tone_melody_sequencer;
   import ptms_pkg::*;
   import ptms_tb_pkg::*;

   localparam int unsigned NUM_PHASES      = 6;
   localparam int unsigned ITEMS_PER_PHASE = 180;
   localparam int unsigned HOLD_CYCLES     = 200;   // long rsp stall, fills the block
   localparam int unsigned SETTLE_CYCLES   = 40;    // > slowest command (serial divider)
   localparam int unsigned WATCHDOG_LIMIT  = 3000;  // cycles with no beat on any channel
   localparam int unsigned MAX_RUN_TICKS   = 120;
   localparam int unsigned CLOCK_MAX_HZ    = 133000000;

   logic clock = 1'b0;
   logic reset;

   ptms_req_if req_bus ();
   ptms_rsp_if rsp_bus ();
   ptms_csr_if csr_bus ();

   pwm_tone_melody_sequencer uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   tone_scoreboard status_board;

   int unsigned send_idle_pct;       // chance per cycle that the command side idles
   int unsigned take_idle_pct;       // chance per cycle that the status side stalls
   int unsigned holds_asked = 0;     // long stalls asked for by the main thread
   int unsigned holds_given = 0;     // long stalls started by the status side
   int unsigned hold_left = 0;
   int unsigned items_sent;
   int unsigned quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Status sink: checks every accepted beat, then picks next ready.
   // Ready is sampled as driven on the previous edge, so the handshake
   // seen here is the one the block sees.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : status_sink
      pwm_status_type got;
      if (rsp_bus.valid && rsp_bus.ready) begin
         got.pwm_period  = rsp_bus.pwm_period;
         got.pwm_level   = rsp_bus.pwm_level;
         got.tone_busy   = rsp_bus.tone_busy;
         got.melody_busy = rsp_bus.melody_busy;
         status_board.check_status(got);
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (holds_given != holds_asked) begin
         // long hold-off, counted here; the command side keeps pushing
         holds_given   = holds_given + 1;
         hold_left     = HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // Watchdog: any beat on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d status beats outstanding",
                     quiet_cycles, status_board.pending());
            $display("tb_pwm_tone_melody_sequencer: FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Command side
   // ------------------------------------------------------------------
   function automatic tone_cmd_type make_cmd(logic [OP_W-1:0] op, int unsigned freq,
                                             int unsigned dur, int unsigned slot,
                                             int unsigned notes);
      tone_cmd_type cmd;
      cmd.operation    = op;
      cmd.frequency    = FREQ_W'(freq);
      cmd.length_ms    = DUR_W'(dur);
      cmd.note_slot    = NSLOT_W'(slot);
      cmd.melody_notes = COUNT_W'(notes);
      return cmd;
   endfunction

   // Ticks are the commonest op so that tones and notes actually run out; short durations
   // dominate, with the odd full-range one. Fields unused by an op stay random.
   function automatic tone_cmd_type random_command();
      tone_cmd_type cmd;
      int unsigned  pick;
      case ($urandom_range(9))
         0:       cmd.frequency = '0;
         1, 2, 3: cmd.frequency = FREQ_W'($urandom_range(2000, 1));
         4:       cmd.frequency = FREQ_W'($urandom_range(15, 1));
         default: cmd.frequency = FREQ_W'($urandom_range(65535));
      endcase
      pick = $urandom_range(9);
      if (pick < 6)      cmd.length_ms = DUR_W'($urandom_range(4));
      else if (pick < 9) cmd.length_ms = DUR_W'($urandom_range(30, 5));
      else               cmd.length_ms = DUR_W'($urandom_range(65535));
      cmd.note_slot    = NSLOT_W'($urandom_range(7));
      cmd.melody_notes = COUNT_W'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 48)      cmd.operation = OP_TICK;
      else if (pick < 62) cmd.operation = OP_TONE;
      else if (pick < 74) cmd.operation = OP_WRITE;
      else if (pick < 86) cmd.operation = OP_MELODY;
      else if (pick < 96) cmd.operation = OP_STOP;
      else                cmd.operation = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      return cmd;
   endfunction

   // One command beat; random idle cycles ahead of it.
   task automatic send_command(input tone_cmd_type cmd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.operation    <= cmd.operation;
      req_bus.frequency    <= cmd.frequency;
      req_bus.length_ms    <= cmd.length_ms;
      req_bus.note_slot    <= cmd.note_slot;
      req_bus.melody_notes <= cmd.melody_notes;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      status_board.note_command(cmd);
      items_sent++;
   endtask

   // Drops valid and waits until every expected status beat is back.
   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (status_board.pending() != 0) @(posedge clock);
   endtask

   // Clock register write, only with nothing in flight.
   task automatic write_tone_clock(input logic [CLK_W-1:0] hz);
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= hz;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      status_board.set_tone_clock(hz);
   endtask

   // Ticks the current tone or melody out, with a little noise mixed in.
   task automatic tick_until_quiet();
      int unsigned ticks;
      ticks = 0;
      while (status_board.busy() && ticks < MAX_RUN_TICKS) begin
         if ($urandom_range(99) < 5) send_command(random_command());
         else send_command(make_cmd(OP_TICK, $urandom_range(65535), $urandom_range(65535),
                                    $urandom_range(7), $urandom_range(15)));
         ticks++;
      end
   endtask

   // Mostly well-formed melody: load notes, start, tick through to the end.
   task automatic play_melody_run();
      tone_cmd_type cmd;
      int unsigned  count;
      count = $urandom_range(8, 1);
      for (int unsigned k = 0; k < count; k++) begin
         cmd             = random_command();
         cmd.operation   = OP_WRITE;
         cmd.note_slot   = ($urandom_range(9) < 8) ? NSLOT_W'(k) : NSLOT_W'($urandom_range(7));
         cmd.length_ms   = DUR_W'($urandom_range(5));
         send_command(cmd);
      end
      cmd              = random_command();
      cmd.operation    = OP_MELODY;
      cmd.length_ms    = DUR_W'($urandom_range(5));
      cmd.melody_notes = ($urandom_range(3) == 0) ? COUNT_W'($urandom_range(15))
                                                  : COUNT_W'(count);
      send_command(cmd);
      tick_until_quiet();
   endtask

   // Directed opening. All eight slots are written before any melody that
   // could walk past slot 0, so no never-written note is ever played.
   task automatic run_directed();
      send_command(make_cmd(OP_TICK, 0, 0, 0, 0));               // tick while idle
      send_command(make_cmd(OP_TONE, 65535, 65535, 7, 15));      // field maxima
      send_command(make_cmd(OP_TICK, 0, 0, 0, 0));
      send_command(make_cmd(OP_STOP, 0, 0, 0, 0));
      send_command(make_cmd(OP_TONE, 1, 1, 0, 0));               // largest divider
      send_command(make_cmd(OP_TICK, 0, 0, 0, 0));               // expires on first tick
      send_command(make_cmd(OP_WRITE, 0, 0, 0, 0));              // rest in the queue
      send_command(make_cmd(OP_WRITE, 1, 0, 1, 0));
      send_command(make_cmd(OP_WRITE, 65535, 1, 2, 0));
      send_command(make_cmd(OP_WRITE, 440, 0, 3, 0));
      send_command(make_cmd(OP_WRITE, 0, 0, 4, 0));
      send_command(make_cmd(OP_WRITE, 2000, 0, 5, 0));
      send_command(make_cmd(OP_WRITE, 7, 0, 6, 0));
      send_command(make_cmd(OP_WRITE, 65535, 0, 7, 0));
      send_command(make_cmd(OP_MELODY, 440, 0, 0, 15));          // count saturates to depth
      tick_until_quiet();
      send_command(make_cmd(OP_MELODY, 0, 3, 0, 1));
      send_command(make_cmd(OP_TONE, 1000, 0, 0, 0));            // tone cancels the melody
      send_command(make_cmd(OP_UNUSED_LO, 1234, 56, 3, 9));
      send_command(make_cmd(OP_UNUSED_HI, 65535, 65535, 7, 15));
   endtask

   // ------------------------------------------------------------------
   // Main sequence: reset, directed part, then six random phases, each
   // with its own tone clock setting and one of three idle profiles.
   // ------------------------------------------------------------------
   initial begin
      int unsigned       phase_start;
      logic [CLK_W-1:0]  hz;
      bit                did_hold;
      bit                did_pause;

      status_board  = new();
      send_idle_pct = 38;
      take_idle_pct = 54;
      items_sent    = 0;

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.operation    <= OP_TICK;
      req_bus.frequency    <= '0;
      req_bus.length_ms    <= '0;
      req_bus.note_slot    <= '0;
      req_bus.melody_notes <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.data         <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
         // receiver-heavy idling, then sender-heavy, then none
         if (phase < 2) begin
            send_idle_pct = 38;
            take_idle_pct = 54;
         end else if (phase < 4) begin
            send_idle_pct = 54;
            take_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end

         // phase 0 keeps the reset clock; the rest hit the extremes, zero
         // (every divider is zero) and random values, low ones included
         case (phase)
            0:       hz = CLOCK_RESET;
            1:       hz = CLK_W'(1);
            2:       hz = CLK_W'(CLOCK_MAX_HZ);
            3:       hz = '0;
            4:       hz = CLK_W'($urandom_range(CLOCK_MAX_HZ, 1000));
            default: hz = CLK_W'($urandom_range(70000, 1));
         endcase
         if (phase == 0) run_directed();
         else write_tone_clock(hz);

         phase_start = items_sent;
         did_hold    = 1'b0;
         did_pause   = 1'b0;
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            if (!did_hold && items_sent - phase_start >= 60) begin
               holds_asked++;
               did_hold = 1'b1;
            end
            if (!did_pause && items_sent - phase_start >= 120) begin
               pause_until_drained();
               did_pause = 1'b1;
            end
            if ($urandom_range(99) < 20) play_melody_run();
            else send_command(random_command());
         end
      end

      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (status_board.pending() != 0) begin
         $error("%0d status beats never arrived", status_board.pending());
         status_board.errors++;
      end

      $display("%0d commands: %0d tick, %0d tone, %0d write, %0d melody, %0d stop, %0d other",
               items_sent, status_board.op_seen[OP_TICK], status_board.op_seen[OP_TONE],
               status_board.op_seen[OP_WRITE], status_board.op_seen[OP_MELODY],
               status_board.op_seen[OP_STOP], status_board.unknown_seen);
      $display("%0d beats checked, %0d clock settings, %0d queued notes, %0d melodies ended",
               status_board.checked, NUM_PHASES, status_board.notes_played,
               status_board.melodies_done);
      if (status_board.errors == 0) begin
         $display("tb_pwm_tone_melody_sequencer: PASS");
      end else begin
         $display("tb_pwm_tone_melody_sequencer: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/ptms_pkg.sv
rtl/ptms_if.sv
rtl/ptms_note_ram.sv
rtl/ptms_div.sv
rtl/pwm_tone_melody_sequencer.sv
test/ptms_tb_pkg.sv
test/tb_pwm_tone_melody_sequencer.sv
